@@ rtl/mog3_pkg.sv @@
package mog3_pkg;

    localparam int SAMPLE_BITS = 16;

    localparam logic [16:0] Q_ONE   = 17'h10000;
    localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

    localparam logic [7:0] INIT_SIGMA_RST = 8'd26;
    localparam logic [7:0] MIN_SIGMA_RST  = 8'd5;
    localparam logic [7:0] THRESH_RST     = 8'd40;

    localparam logic [1:0] CFG_INIT_SIGMA = 2'd0;
    localparam logic [1:0] CFG_MIN_SIGMA  = 2'd1;
    localparam logic [1:0] CFG_THRESH     = 2'd2;

    localparam logic [1:0] MATCH_M0   = 2'd0;
    localparam logic [1:0] MATCH_M1   = 2'd1;
    localparam logic [1:0] MATCH_M2   = 2'd2;
    localparam logic [1:0] MATCH_NONE = 2'd3;

    localparam int DIV_NB  = 34;
    localparam int DIV_DB  = 33;
    localparam int DIV_QB  = 17;
    localparam int DIV_LAT = DIV_QB + 1;

    localparam int SQ_IB  = 34;
    localparam int SQ_RB  = SQ_IB / 2;
    localparam int SQ_LAT = SQ_RB;

    typedef logic [16:0] q_t;

    typedef struct packed {
        q_t          mu;
        q_t          sg;
        q_t          wt;
        logic [24:0] n;
    } mode_t;

    typedef struct packed {
        logic [DIV_NB-1:0] rem;
        logic [DIV_QB-1:0] low;
        logic [DIV_QB-1:0] quo;
    } div_st_t;

    typedef struct packed {
        logic [SQ_RB+2:0]  rem;
        logic [SQ_RB-1:0]  root;
        logic [SQ_IB-1:0]  rad;
    } sq_st_t;

    function automatic q_t byte_to_q(logic [7:0] b);
        return 17'({b, 8'h00}) + 17'(b) + 17'(b != 8'd0);
    endfunction

    function automatic logic [7:0] q_to_byte(q_t v);
        q_t          c;
        logic [24:0] p;
        c = (v > Q_ONE) ? Q_ONE : v;
        p = {c, 8'h00} - 25'(c);
        return p[23:16];
    endfunction

    function automatic div_st_t div_step(div_st_t s, logic [DIV_DB-1:0] den);
        div_st_t           r;
        logic [DIV_NB-1:0] t;
        logic              ge;
        t     = {s.rem[DIV_NB-2:0], s.low[DIV_QB-1]};
        ge    = t >= DIV_NB'(den);
        r.rem = ge ? (t - DIV_NB'(den)) : t;
        r.low = {s.low[DIV_QB-2:0], 1'b0};
        r.quo = {s.quo[DIV_QB-2:0], ge};
        return r;
    endfunction

    function automatic sq_st_t sq_step(sq_st_t s);
        sq_st_t           r;
        logic [SQ_RB+2:0] t;
        logic [SQ_RB+2:0] trial;
        logic             ge;
        t      = {s.rem[SQ_RB:0], s.rad[SQ_IB-1:SQ_IB-2]};
        trial  = {1'b0, s.root, 2'b01};
        ge     = t >= trial;
        r.rem  = ge ? (t - trial) : t;
        r.root = {s.root[SQ_RB-2:0], ge};
        r.rad  = {s.rad[SQ_IB-3:0], 2'b00};
        return r;
    endfunction

endpackage

@@ rtl/mog3_div.sv @@
module mog3_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [mog3_pkg::DIV_NB-1:0]   num,
    input  logic [mog3_pkg::DIV_DB-1:0]   den,
    output logic [mog3_pkg::DIV_QB-1:0]   quo
);
    import mog3_pkg::*;

    div_st_t           st_reg  [DIV_LAT];
    logic [DIV_DB-1:0] den_reg [DIV_LAT];
    div_st_t           st_next;

    always_comb
    begin
        st_next.rem = DIV_NB'(num[DIV_NB-1:DIV_QB]);
        st_next.low = num[DIV_QB-1:0];
        st_next.quo = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]  <= st_next;
            den_reg[0] <= den;
        end
    end

    for (genvar k = 1; k < DIV_LAT; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k]  <= div_step(st_reg[k-1], den_reg[k-1]);
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quo = st_reg[DIV_LAT-1].quo;

endmodule

@@ rtl/mog3_sqrt.sv @@
module mog3_sqrt (
    input  logic                        clk,
    input  logic                        en,
    input  logic [mog3_pkg::SQ_IB-1:0]  rad,
    output logic [mog3_pkg::SQ_RB-1:0]  root
);
    import mog3_pkg::*;

    sq_st_t st_reg [SQ_LAT];
    sq_st_t st_init;

    always_comb
    begin
        st_init.rem  = '0;
        st_init.root = '0;
        st_init.rad  = rad;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= sq_step(st_init);
        end
    end

    for (genvar k = 1; k < SQ_LAT; k++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= sq_step(st_reg[k-1]);
            end
        end
    end

    assign root = st_reg[SQ_LAT-1].root;

endmodule

@@ rtl/mog3_sort.sv @@
module mog3_sort (
    input  logic                        clk,
    input  logic                        en,
    input  mog3_pkg::mode_t [2:0]       modes_in,
    output mog3_pkg::mode_t [2:0]       modes_out
);
    import mog3_pkg::*;

    typedef enum logic [2:0] {
        ORD_012,
        ORD_102,
        ORD_210,
        ORD_120,
        ORD_021,
        ORD_201
    } ord_t;

    ord_t             ord_next;
    ord_t             ord_reg;
    mode_t [2:0]      mode_reg;
    logic             v1;
    logic             v2;
    logic             ab;
    logic             bc;
    logic             ac;

    always_comb
    begin
        v1 = (modes_in[1].wt != '0) && (modes_in[1].sg != '0);
        v2 = (modes_in[2].wt != '0) && (modes_in[2].sg != '0);
        ab = (34'(modes_in[0].wt) * 34'(modes_in[1].sg))
           < (34'(modes_in[1].wt) * 34'(modes_in[0].sg));
        bc = (34'(modes_in[1].wt) * 34'(modes_in[2].sg))
           < (34'(modes_in[2].wt) * 34'(modes_in[1].sg));
        ac = (34'(modes_in[0].wt) * 34'(modes_in[2].sg))
           < (34'(modes_in[2].wt) * 34'(modes_in[0].sg));
        if (!v1)
            ord_next = ORD_012;
        else if (!v2)
            ord_next = ab ? ORD_102 : ORD_012;
        else if (!ab && !bc)
            ord_next = ORD_012;
        else if (ab && bc)
            ord_next = ORD_210;
        else if (ab)
            ord_next = ac ? ORD_120 : ORD_102;
        else
            ord_next = ac ? ORD_201 : ORD_021;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ord_reg  <= ord_next;
            mode_reg <= modes_in;
        end
    end

    always_comb
    begin
        unique case (ord_reg)
            ORD_102: modes_out = {mode_reg[2], mode_reg[0], mode_reg[1]};
            ORD_210: modes_out = {mode_reg[0], mode_reg[1], mode_reg[2]};
            ORD_120: modes_out = {mode_reg[0], mode_reg[2], mode_reg[1]};
            ORD_021: modes_out = {mode_reg[1], mode_reg[2], mode_reg[0]};
            ORD_201: modes_out = {mode_reg[1], mode_reg[0], mode_reg[2]};
            default: modes_out = mode_reg;
        endcase
    end

endmodule

@@ rtl/mog3_pixel_model_update.sv @@
// channel   direction  handshake            payload
// in        sink       in_valid/in_stall    model_word, component0..2_count, total_count,
//                                           sample, obs_weight
// out       source     out_valid/out_stall  new_model_word, new_component0..2_count,
//                                           new_total_count, matched_component
// cfg       sink       cfg_write            cfg_index, cfg_data
//
// One item per cycle while the output is not stalled.
// Two restoring divider stages run in series, the second with two dividers side by side, then a square root.
// rst_n clears valid bits, output valid and the three registers to their defaults.
// A stalled output holds the whole pipeline; in_stall follows it in the same cycle.
module mog3_pixel_model_update (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] model_word,
    input  logic [23:0] component0_count,
    input  logic [23:0] component1_count,
    input  logic [23:0] component2_count,
    input  logic [23:0] total_count,
    input  logic [15:0] sample,
    input  logic [15:0] obs_weight,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] new_model_word,
    output logic [23:0] new_component0_count,
    output logic [23:0] new_component1_count,
    output logic [23:0] new_component2_count,
    output logic [23:0] new_total_count,
    output logic [1:0]  matched_component,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import mog3_pkg::*;

    typedef struct packed {
        logic [63:0]       word;
        logic [2:0][23:0]  cnt;
        logic [23:0]       tot_out;
        logic              zero;
        logic [15:0]       x;
        logic [15:0]       w;
        logic [32:0]       total;
        mode_t [2:0]       m;
        q_t                alpha;
        q_t                keep;
        logic [2:0][16:0]  d;
        logic [2:0]        up;
        logic [2:0][24:0]  st;
        logic [2:0][16:0]  nw;
        logic [2:0]        vm;
        logic [2:0]        inr;
        logic [1:0]        mt;
        logic [1:0]        sel;
        logic              adapt;
        logic              renorm;
        q_t                dm;
        logic              upm;
        logic [33:0]       sgsq;
        q_t                rho;
        logic [33:0]       rd;
        logic [33:0]       t;
        logic [33:0]       vr;
    } item_t;

    logic              adv;
    logic [7:0]        init_sigma_reg;
    logic [7:0]        min_sigma_reg;
    logic [7:0]        thresh_reg;

    item_t             dec_next, dec_reg;
    item_t             ln1_reg [DIV_LAT];
    item_t             dcy_next, dcy_reg;
    item_t             mch_next, mch_reg;
    item_t             app_next;
    item_t             ln2_reg [DIV_LAT];
    item_t             rho_next, rho_reg;
    item_t             t_next, t_reg;
    item_t             var_next, var_reg;
    item_t             ln3_reg [SQ_LAT];
    item_t             sg_next, sg_reg;
    item_t             side_reg;

    logic              dec_vld_reg;
    logic [DIV_LAT-1:0] ln1_vld_reg;
    logic              dcy_vld_reg;
    logic              mch_vld_reg;
    logic [DIV_LAT-1:0] ln2_vld_reg;
    logic              rho_vld_reg;
    logic              t_vld_reg;
    logic              var_vld_reg;
    logic [SQ_LAT-1:0] ln3_vld_reg;
    logic              sg_vld_reg;
    logic              side_vld_reg;
    logic              out_valid_reg;

    logic [DIV_QB-1:0] q1;
    logic [DIV_QB-1:0] qa;
    logic [DIV_QB-1:0] qb;
    logic [DIV_NB-1:0] num_a, num_b;
    logic [DIV_DB-1:0] den_a, den_b;
    logic [SQ_RB-1:0]  root;
    mode_t [2:0]       sorted;

    logic [63:0]       word_next, word_reg;
    logic [2:0][23:0]  cnt_next, cnt_reg;
    logic [23:0]       tot_reg;
    logic [1:0]        mt_reg;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_sigma_reg <= INIT_SIGMA_RST;
            min_sigma_reg  <= MIN_SIGMA_RST;
            thresh_reg     <= THRESH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_INIT_SIGMA: init_sigma_reg <= cfg_data;
                CFG_MIN_SIGMA:  min_sigma_reg  <= cfg_data;
                CFG_THRESH:     thresh_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // decode
    always_comb
    begin
        logic [39:0] xs;
        logic [17:0] wsum;
        logic [24:0] tsum;
        dec_next = '0;
        dec_next.word = model_word;
        dec_next.cnt  = {component2_count, component1_count, component0_count};
        for (int i = 0; i < 3; i++)
        begin
            dec_next.m[i].mu = byte_to_q(model_word[24*i +: 8]);
            dec_next.m[i].n  = 25'(dec_next.cnt[i]);
        end
        dec_next.m[0].sg = byte_to_q(model_word[15:8]);
        dec_next.m[1].sg = byte_to_q(model_word[39:32]);
        dec_next.m[2].sg = byte_to_q(model_word[63:56]);
        dec_next.m[0].wt = byte_to_q(model_word[23:16]);
        dec_next.m[1].wt = byte_to_q(model_word[47:40]);
        wsum = 18'(dec_next.m[0].wt) + 18'(dec_next.m[1].wt);
        if ((dec_next.m[0].wt != '0) && (dec_next.m[1].wt != '0) && (wsum < 18'(Q_ONE)))
            dec_next.m[2].wt = Q_ONE - wsum[16:0];
        else
            dec_next.m[2].wt = '0;
        xs = ((40'(sample) & ((40'd1 << SAMPLE_BITS) - 40'd1)) << 16) >> SAMPLE_BITS;
        dec_next.x     = xs[15:0];
        dec_next.w     = obs_weight;
        dec_next.zero  = (obs_weight == 16'd0);
        dec_next.total = {1'b0, total_count, 8'h00} + 33'(obs_weight);
        tsum = 25'(total_count) + 25'(obs_weight[15:8]);
        dec_next.tot_out = tsum[24] ? CNT_MAX : tsum[23:0];
    end

    mog3_div u_div1 (
        .clk (clk),
        .en  (adv),
        .num ({2'b00, dec_reg.w, 16'h0000}),
        .den (dec_reg.total),
        .quo (q1)
    );

    // decay and distance
    always_comb
    begin
        logic [16:0] xe;
        logic [33:0] pk;
        dcy_next       = ln1_reg[DIV_LAT-1];
        dcy_next.alpha = q1;
        dcy_next.keep  = Q_ONE - q1;
        xe = 17'(dcy_next.x);
        for (int i = 0; i < 3; i++)
        begin
            dcy_next.up[i] = xe >= dcy_next.m[i].mu;
            dcy_next.d[i]  = dcy_next.up[i] ? (xe - dcy_next.m[i].mu)
                                            : (dcy_next.m[i].mu - xe);
            dcy_next.st[i] = 25'(dcy_next.m[i].sg) * 25'(thresh_reg);
            pk = 34'(dcy_next.keep) * 34'(dcy_next.m[i].wt);
            dcy_next.nw[i] = pk[32:16];
            dcy_next.vm[i] = (dcy_next.m[i].wt != '0) && (dcy_next.m[i].sg != '0);
        end
    end

    // match search
    always_comb
    begin
        logic [33:0] dd;
        logic [49:0] ss;
        logic        found;
        mch_next    = dcy_reg;
        mch_next.mt = MATCH_NONE;
        found       = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            dd = 34'(dcy_reg.d[i]) * 34'(dcy_reg.d[i]);
            ss = 50'(dcy_reg.st[i]) * 50'(dcy_reg.st[i]);
            mch_next.inr[i] = 50'({dd, 8'h00}) < ss;
            if (!found && dcy_reg.vm[i] && mch_next.inr[i])
            begin
                mch_next.mt = 2'(i);
                found       = 1'b1;
            end
        end
    end

    // apply weights, pick branch, load dividers
    always_comb
    begin
        q_t          initq;
        logic [17:0] s;
        logic [33:0] pa0, pa1;
        mode_t       ins;
        app_next        = mch_reg;
        initq           = byte_to_q(init_sigma_reg);
        app_next.adapt  = mch_reg.mt != MATCH_NONE;
        app_next.renorm = 1'b0;
        app_next.sel    = app_next.adapt ? mch_reg.mt : MATCH_M0;
        ins.mu = 17'(mch_reg.x);
        ins.sg = initq;
        ins.wt = mch_reg.alpha;
        ins.n  = 25'd256;
        for (int i = 0; i < 3; i++)
        begin
            if (mch_reg.vm[i])
                app_next.m[i].wt = mch_reg.nw[i]
                                 + ((mch_reg.mt == 2'(i)) ? mch_reg.alpha : 17'd0);
        end
        if (app_next.adapt)
        begin
            app_next.m[app_next.sel].n = app_next.m[app_next.sel].n + 25'd256;
        end
        else if ((app_next.m[1].wt != '0) && (app_next.m[1].sg != '0))
        begin
            app_next.renorm = 1'b1;
            app_next.m[2]   = ins;
            app_next.mt     = MATCH_M2;
        end
        else if (app_next.m[0].wt != '0)
        begin
            app_next.m[0].wt = mch_reg.keep;
            app_next.m[1]    = ins;
            app_next.mt      = MATCH_M1;
        end
        else
        begin
            app_next.m[0]    = ins;
            app_next.m[0].wt = Q_ONE;
            app_next.mt      = MATCH_M0;
        end
        app_next.dm   = mch_reg.d[app_next.sel];
        app_next.upm  = mch_reg.up[app_next.sel];
        app_next.sgsq = 34'(mch_reg.m[app_next.sel].sg) * 34'(mch_reg.m[app_next.sel].sg);
        s   = 18'(app_next.m[0].wt) + 18'(app_next.m[1].wt);
        pa0 = 34'(app_next.m[0].wt) * 34'(mch_reg.keep);
        pa1 = 34'(app_next.m[1].wt) * 34'(mch_reg.keep);
        num_a = app_next.adapt ? DIV_NB'({mch_reg.keep, 8'h00}) : pa0;
        den_a = app_next.adapt ? DIV_DB'(app_next.m[app_next.sel].n) : DIV_DB'(s);
        num_b = pa1;
        den_b = DIV_DB'(s);
    end

    mog3_div u_div_a (
        .clk (clk),
        .en  (adv),
        .num (num_a),
        .den (den_a),
        .quo (qa)
    );

    mog3_div u_div_b (
        .clk (clk),
        .en  (adv),
        .num (num_b),
        .den (den_b),
        .quo (qb)
    );

    // learning rate
    always_comb
    begin
        rho_next     = ln2_reg[DIV_LAT-1];
        rho_next.rho = qa + rho_next.alpha;
        if (rho_next.renorm)
        begin
            rho_next.m[0].wt = qa;
            rho_next.m[1].wt = qb;
        end
        rho_next.rd = 34'(rho_next.rho) * 34'(rho_next.dm);
    end

    // mean step and variance sum
    always_comb
    begin
        logic [50:0] rdd;
        q_t          stp;
        t_next = rho_reg;
        rdd    = 51'(rho_reg.rd) * 51'(rho_reg.dm);
        t_next.t = rho_reg.sgsq + rdd[49:16];
        stp = rho_reg.rd[32:16];
        if (rho_reg.adapt)
            t_next.m[rho_reg.sel].mu = rho_reg.upm ? (rho_reg.m[rho_reg.sel].mu + stp)
                                                   : (rho_reg.m[rho_reg.sel].mu - stp);
    end

    // variance scale
    always_comb
    begin
        logic [50:0] pv;
        var_next = t_reg;
        pv       = 51'(t_reg.t) * 51'(Q_ONE - t_reg.rho);
        var_next.vr = pv[49:16];
    end

    mog3_sqrt u_sqrt (
        .clk  (clk),
        .en   (adv),
        .rad  (var_reg.vr),
        .root (root)
    );

    // sigma floor
    always_comb
    begin
        q_t mins;
        sg_next = ln3_reg[SQ_LAT-1];
        mins    = byte_to_q(min_sigma_reg);
        if (sg_next.adapt)
            sg_next.m[sg_next.sel].sg = (root < mins) ? mins : root;
    end

    mog3_sort u_sort (
        .clk       (clk),
        .en        (adv),
        .modes_in  (sg_reg.m),
        .modes_out (sorted)
    );

    // pack
    always_comb
    begin
        if (side_reg.zero)
        begin
            word_next = side_reg.word;
            cnt_next  = side_reg.cnt;
        end
        else
        begin
            word_next = {q_to_byte(sorted[2].sg), q_to_byte(sorted[2].mu),
                         q_to_byte(sorted[1].wt), q_to_byte(sorted[1].sg),
                         q_to_byte(sorted[1].mu), q_to_byte(sorted[0].wt),
                         q_to_byte(sorted[0].sg), q_to_byte(sorted[0].mu)};
            for (int i = 0; i < 3; i++)
                cnt_next[i] = sorted[i].n[24] ? CNT_MAX : sorted[i].n[23:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_vld_reg   <= 1'b0;
            ln1_vld_reg   <= '0;
            dcy_vld_reg   <= 1'b0;
            mch_vld_reg   <= 1'b0;
            ln2_vld_reg   <= '0;
            rho_vld_reg   <= 1'b0;
            t_vld_reg     <= 1'b0;
            var_vld_reg   <= 1'b0;
            ln3_vld_reg   <= '0;
            sg_vld_reg    <= 1'b0;
            side_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dec_vld_reg   <= in_valid;
            ln1_vld_reg   <= {ln1_vld_reg[DIV_LAT-2:0], dec_vld_reg};
            dcy_vld_reg   <= ln1_vld_reg[DIV_LAT-1];
            mch_vld_reg   <= dcy_vld_reg;
            ln2_vld_reg   <= {ln2_vld_reg[DIV_LAT-2:0], mch_vld_reg};
            rho_vld_reg   <= ln2_vld_reg[DIV_LAT-1];
            t_vld_reg     <= rho_vld_reg;
            var_vld_reg   <= t_vld_reg;
            ln3_vld_reg   <= {ln3_vld_reg[SQ_LAT-2:0], var_vld_reg};
            sg_vld_reg    <= ln3_vld_reg[SQ_LAT-1];
            side_vld_reg  <= sg_vld_reg;
            out_valid_reg <= side_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dec_reg    <= dec_next;
            ln1_reg[0] <= dec_reg;
            for (int k = 1; k < DIV_LAT; k++)
                ln1_reg[k] <= ln1_reg[k-1];
            dcy_reg    <= dcy_next;
            mch_reg    <= mch_next;
            ln2_reg[0] <= app_next;
            for (int k = 1; k < DIV_LAT; k++)
                ln2_reg[k] <= ln2_reg[k-1];
            rho_reg    <= rho_next;
            t_reg      <= t_next;
            var_reg    <= var_next;
            ln3_reg[0] <= var_reg;
            for (int k = 1; k < SQ_LAT; k++)
                ln3_reg[k] <= ln3_reg[k-1];
            sg_reg     <= sg_next;
            side_reg   <= sg_reg;
            word_reg   <= word_next;
            cnt_reg    <= cnt_next;
            tot_reg    <= side_reg.tot_out;
            mt_reg     <= side_reg.zero ? MATCH_NONE : side_reg.mt;
        end
    end

    assign out_valid            = out_valid_reg;
    assign new_model_word       = word_reg;
    assign new_component0_count = cnt_reg[0];
    assign new_component1_count = cnt_reg[1];
    assign new_component2_count = cnt_reg[2];
    assign new_total_count      = tot_reg;
    assign matched_component    = mt_reg;

`ifndef SYNTHESIS
    a_update_has_mode: assert property (@(posedge clk) disable iff (!rst_n)
        rho_vld_reg && !rho_reg.zero |-> rho_reg.mt != MATCH_NONE)
        else $error("updated item has no matched or inserted mode");

    a_renorm_inserts_last: assert property (@(posedge clk) disable iff (!rst_n)
        rho_vld_reg && rho_reg.renorm |-> rho_reg.mt == MATCH_M2 && !rho_reg.adapt)
        else $error("renormalize without insert into third mode");

    a_stall_holds_var: assert property (@(posedge clk) disable iff (!rst_n)
        var_vld_reg && !adv |=> var_vld_reg && $stable(var_reg.vr))
        else $error("variance stage changed under stall");

    a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall)
        else $error("input stalled while output free");
`endif

endmodule
